FILE: hw/rtl/tkchd_pkg.sv
// ----------------------------------------------------------------------------
// tkchd_pkg
// Shared types, codes and helper functions for the two-key click/hold
// detector.
// ----------------------------------------------------------------------------
package tkchd_pkg;

    localparam int COUNT_WIDTH_DEF = 16;
    localparam int THR_W           = 16;
    localparam int POLL_W          = 8;
    localparam int CFG_IDX_W       = 3;
    localparam int CFG_DATA_W      = 16;
    localparam int S_DATA_W        = 8;
    localparam int M_DATA_W        = 16;

    localparam logic [POLL_W-1:0] DEFAULT_POLL_MS = 8'd10;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_PRESS_LOW   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_POLL_MS     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HOLD_THR    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CLICK_THR   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_RELEASE_THR = 3'd4;

    typedef enum logic [1:0] {
        STEP_WAIT     = 2'd0,
        STEP_DEBOUNCE = 2'd1,
        STEP_HOLD     = 2'd2
    } scan_step_t;

    typedef enum logic [1:0] {
        LEV_NONE = 2'd0,
        LEV_UP   = 2'd1,
        LEV_DOWN = 2'd2,
        LEV_BOTH = 2'd3
    } level_t;

    typedef enum logic [1:0] {
        KIND_NONE  = 2'd0,
        KIND_CLICK = 2'd1,
        KIND_ENTER = 2'd2,
        KIND_CONT  = 2'd3
    } press_kind_t;

    // key status codes
    localparam logic [3:0] ST_IDLE       = 4'd0;
    localparam logic [3:0] ST_UP_CLICK   = 4'd1;
    localparam logic [3:0] ST_UP_ENTER   = 4'd2;
    localparam logic [3:0] ST_UP_CONT    = 4'd3;
    localparam logic [3:0] ST_DN_CLICK   = 4'd4;
    localparam logic [3:0] ST_DN_ENTER   = 4'd5;
    localparam logic [3:0] ST_DN_CONT    = 4'd6;
    localparam logic [3:0] ST_BOTH_CLICK = 4'd7;
    localparam logic [3:0] ST_BOTH_ENTER = 4'd8;
    localparam logic [3:0] ST_BOTH_CONT  = 4'd9;

    // application key index and event kind
    localparam logic [1:0] APP_KEY_UP      = 2'd0;
    localparam logic [1:0] APP_KEY_DOWN    = 2'd1;
    localparam logic [1:0] APP_KEY_BOTH    = 2'd2;
    localparam logic [1:0] APP_EV_CLICK    = 2'd0;
    localparam logic [1:0] APP_EV_LONG     = 2'd1;
    localparam logic [1:0] APP_EV_DUAL     = 2'd2;

    typedef struct packed {
        logic              press_low;
        logic [POLL_W-1:0] poll_ms;
        logic [THR_W-1:0]  hold_thr;
        logic [THR_W-1:0]  click_thr;
        logic [THR_W-1:0]  release_thr;
    } cfg_t;

    typedef struct packed {
        logic read_ok;
        logic down_pin_level;
        logic up_pin_level;
    } pin_item_t;

    typedef struct packed {
        logic [1:0] app_event_kind;
        logic [1:0] app_key_index;
        logic       app_event_valid;
        logic [3:0] key_status;
    } result_t;

    function automatic logic [3:0] status_of(level_t lev, press_kind_t kind);
        logic [3:0] st;
        st = ST_IDLE;
        case (lev)
            LEV_UP:   st = 4'(kind);
            LEV_DOWN: st = 4'(kind) + 4'd3;
            LEV_BOTH: st = 4'(kind) + 4'd6;
            default:  st = ST_IDLE;
        endcase
        return st;
    endfunction

    function automatic result_t result_of(logic [3:0] st);
        result_t r;
        r = '0;
        r.key_status = st;
        case (st)
            ST_UP_CLICK:
            begin
                r.app_event_valid = 1'b1;
                r.app_key_index   = APP_KEY_UP;
                r.app_event_kind  = APP_EV_CLICK;
            end
            ST_UP_ENTER:
            begin
                r.app_event_valid = 1'b1;
                r.app_key_index   = APP_KEY_UP;
                r.app_event_kind  = APP_EV_LONG;
            end
            ST_DN_CLICK:
            begin
                r.app_event_valid = 1'b1;
                r.app_key_index   = APP_KEY_DOWN;
                r.app_event_kind  = APP_EV_CLICK;
            end
            ST_DN_ENTER:
            begin
                r.app_event_valid = 1'b1;
                r.app_key_index   = APP_KEY_DOWN;
                r.app_event_kind  = APP_EV_LONG;
            end
            ST_BOTH_CLICK:
            begin
                r.app_event_valid = 1'b1;
                r.app_key_index   = APP_KEY_BOTH;
                r.app_event_kind  = APP_EV_DUAL;
            end
            // both-keys hold-enter is reported on the up key index
            ST_BOTH_ENTER:
            begin
                r.app_event_valid = 1'b1;
                r.app_key_index   = APP_KEY_UP;
                r.app_event_kind  = APP_EV_LONG;
            end
            default:
            begin
                r.app_event_valid = 1'b0;
            end
        endcase
        return r;
    endfunction

endpackage

FILE: hw/rtl/tkchd_scan.sv
// ----------------------------------------------------------------------------
// tkchd_scan
// Scan state machine: key level decode, debounce/hold counters and status
// for one poll tick. State advances when adv is high.
// ----------------------------------------------------------------------------
module tkchd_scan #(
    parameter int COUNT_WIDTH = tkchd_pkg::COUNT_WIDTH_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  adv,
    input  tkchd_pkg::pin_item_t  item,
    input  tkchd_pkg::cfg_t       cfg,
    output tkchd_pkg::result_t    result
);
    import tkchd_pkg::*;

    localparam int CMP_W = (COUNT_WIDTH > THR_W) ? COUNT_WIDTH : THR_W;

    scan_step_t             step_reg, step_next;
    level_t                 lev_reg, lev_next;
    logic [COUNT_WIDTH-1:0] deb_reg, deb_next;
    logic [COUNT_WIDTH-1:0] hold_reg, hold_next;

    logic                   up_on;
    logic                   dn_on;
    level_t                 lev;
    logic [POLL_W-1:0]      ms;
    logic [COUNT_WIDTH-1:0] deb_sum;
    logic [COUNT_WIDTH-1:0] hold_sum;
    logic [3:0]             status;

    function automatic logic [COUNT_WIDTH-1:0] sat_add(
        logic [COUNT_WIDTH-1:0] a,
        logic [POLL_W-1:0]      b
    );
        logic [COUNT_WIDTH:0] s;
        s = {1'b0, a} + (COUNT_WIDTH+1)'(b);
        return s[COUNT_WIDTH] ? {COUNT_WIDTH{1'b1}} : s[COUNT_WIDTH-1:0];
    endfunction

    function automatic logic at_least(logic [COUNT_WIDTH-1:0] cnt, logic [THR_W-1:0] thr);
        return CMP_W'(cnt) >= CMP_W'(thr);
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= STEP_WAIT;
            lev_reg  <= LEV_NONE;
            deb_reg  <= '0;
            hold_reg <= '0;
        end
        else if (adv)
        begin
            step_reg <= step_next;
            lev_reg  <= lev_next;
            deb_reg  <= deb_next;
            hold_reg <= hold_next;
        end
    end

    always_comb
    begin
        up_on    = item.up_pin_level ^ cfg.press_low;
        dn_on    = item.down_pin_level ^ cfg.press_low;
        lev      = level_t'({dn_on, up_on});
        ms       = (cfg.poll_ms == '0) ? DEFAULT_POLL_MS : cfg.poll_ms;
        deb_sum  = sat_add(deb_reg, ms);
        hold_sum = sat_add(hold_reg, ms);

        step_next = step_reg;
        lev_next  = lev_reg;
        deb_next  = deb_reg;
        hold_next = hold_reg;
        status    = ST_IDLE;

        if (item.read_ok)
        begin
            case (step_reg)
                STEP_WAIT:
                begin
                    if (lev != LEV_NONE)
                    begin
                        deb_next  = '0;
                        hold_next = '0;
                        step_next = STEP_DEBOUNCE;
                        lev_next  = lev;
                    end
                end
                STEP_DEBOUNCE:
                begin
                    if (lev == lev_reg)
                    begin
                        deb_next = deb_sum;
                        if (at_least(deb_sum, cfg.hold_thr))
                        begin
                            step_next = STEP_HOLD;
                            deb_next  = '0;
                            status    = status_of(lev_reg, KIND_ENTER);
                        end
                    end
                    else if (lev == LEV_NONE)
                    begin
                        if (at_least(deb_reg, cfg.click_thr))
                        begin
                            status = status_of(lev_reg, KIND_CLICK);
                        end
                        step_next = STEP_WAIT;
                        deb_next  = '0;
                        hold_next = '0;
                    end
                    else if (lev == LEV_BOTH)
                    begin
                        lev_next = LEV_BOTH;
                        deb_next = '0;
                    end
                    else if (lev_reg == LEV_BOTH && at_least(deb_reg, cfg.click_thr))
                    begin
                        // leaving both-keys after the click time: dual click
                        status    = status_of(LEV_BOTH, KIND_CLICK);
                        step_next = STEP_HOLD;
                        deb_next  = '0;
                        hold_next = '0;
                    end
                    else
                    begin
                        lev_next = lev;
                        deb_next = '0;
                    end
                end
                STEP_HOLD:
                begin
                    if (lev == LEV_NONE)
                    begin
                        deb_next = deb_sum;
                        if (at_least(deb_sum, cfg.release_thr))
                        begin
                            step_next = STEP_WAIT;
                            deb_next  = '0;
                            hold_next = '0;
                        end
                    end
                    else
                    begin
                        deb_next  = '0;
                        hold_next = hold_sum;
                        if (at_least(hold_sum, cfg.hold_thr))
                        begin
                            status    = status_of(lev_reg, KIND_CONT);
                            hold_next = '0;
                        end
                    end
                end
                default:
                begin
                    step_next = STEP_WAIT;
                    deb_next  = '0;
                    hold_next = '0;
                end
            endcase
        end

        result = result_of(status);
    end

endmodule

FILE: hw/rtl/two_key_click_hold_detector_top.sv
// ----------------------------------------------------------------------------
// two_key_click_hold_detector_top
// Two-key click / hold / dual-click detector with stream input and output.
//
//   channel  dir  handshake          payload
//   s_*      in   s_tvalid/s_tready  s_tdata: up, down, read_ok
//   m_*      out  m_tvalid/m_tready  m_tdata: status, ev_valid, key, kind
//   cfg_*    in   cfg_valid/ready    cfg_index, cfg_data
//
// One poll tick per cycle unless the output stalls; input reg, then result reg.
// The scan machine updates as a tick moves from input to result register.
// Output stall holds the result; one more tick is buffered in the input reg.
// rst_n clears the machine and loads register defaults; no clearing pass.
// ----------------------------------------------------------------------------
module two_key_click_hold_detector_top #(
    parameter int COUNT_WIDTH = tkchd_pkg::COUNT_WIDTH_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [tkchd_pkg::S_DATA_W-1:0]      s_tdata,   // up, down, read_ok
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // status[3:0], ev_valid, key[1:0], kind[1:0]
    output logic [tkchd_pkg::M_DATA_W-1:0]      m_tdata,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [tkchd_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [tkchd_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import tkchd_pkg::*;

    cfg_t      cfg_reg;
    logic      in_vld_reg;
    pin_item_t in_item_reg;
    logic      out_vld_reg;
    result_t   out_res_reg;
    result_t   scan_res;
    logic      adv;

    assign cfg_ready = 1'b1;
    assign adv       = in_vld_reg && (!out_vld_reg || m_tready);
    assign s_tready  = !in_vld_reg || adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.press_low   <= 1'b1;
            cfg_reg.poll_ms     <= POLL_W'(10);
            cfg_reg.hold_thr    <= THR_W'(1000);
            cfg_reg.click_thr   <= THR_W'(30);
            cfg_reg.release_thr <= THR_W'(50);
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_PRESS_LOW:   cfg_reg.press_low   <= cfg_data[0];
                CFG_POLL_MS:     cfg_reg.poll_ms     <= cfg_data[POLL_W-1:0];
                CFG_HOLD_THR:    cfg_reg.hold_thr    <= cfg_data[THR_W-1:0];
                CFG_CLICK_THR:   cfg_reg.click_thr   <= cfg_data[THR_W-1:0];
                CFG_RELEASE_THR: cfg_reg.release_thr <= cfg_data[THR_W-1:0];
                default:         ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            if (s_tready)
            begin
                in_vld_reg <= s_tvalid;
            end
            if (adv)
            begin
                out_vld_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_item_reg.up_pin_level   <= s_tdata[0];
            in_item_reg.down_pin_level <= s_tdata[1];
            in_item_reg.read_ok        <= s_tdata[2];
        end
        if (adv)
        begin
            out_res_reg <= scan_res;
        end
    end

    tkchd_scan #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_scan (
        .clk    (clk),
        .rst_n  (rst_n),
        .adv    (adv),
        .item   (in_item_reg),
        .cfg    (cfg_reg),
        .result (scan_res)
    );

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = {7'b0, out_res_reg.app_event_kind, out_res_reg.app_key_index,
                       out_res_reg.app_event_valid, out_res_reg.key_status};

endmodule

FILE: hw/rtl/tkchd_checker.sv
// ----------------------------------------------------------------------------
// tkchd_checker
// Port-level checks for the two-key click/hold detector, bound to the top.
// ----------------------------------------------------------------------------
module tkchd_checker (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            s_tready,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [tkchd_pkg::M_DATA_W-1:0]  m_tdata
);
    import tkchd_pkg::*;

    logic [3:0] st;
    logic       ev;
    logic       ev_expected;

    assign st = m_tdata[3:0];
    assign ev = m_tdata[4];
    assign ev_expected = (st == ST_UP_CLICK) || (st == ST_UP_ENTER) ||
                         (st == ST_DN_CLICK) || (st == ST_DN_ENTER) ||
                         (st == ST_BOTH_CLICK) || (st == ST_BOTH_ENTER);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result transaction changed while stalled");

    a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> st <= ST_BOTH_CONT)
        else $error("key status out of range");

    a_event_map: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> ev == ev_expected)
        else $error("event valid does not match key status");

    a_no_event_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !ev |-> m_tdata[8:5] == 4'd0)
        else $error("event fields set without an event");

    a_flow: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> m_tvalid)
        else $error("input stalled with no pending result");

endmodule

bind two_key_click_hold_detector_top tkchd_checker u_tkchd_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

FILE: tb/sv/tb_two_key_click_hold_detector_top.sv
// ----------------------------------------------------------------------------
// tb_two_key_click_hold_detector_top
// Self-checking bench for the two-key click/hold detector. Poll ticks go in
// on the input stream. A behavioral copy of the scan machine predicts one
// key status and app event per tick. Each output transaction is checked
// against the oldest prediction. Covers reset values, directed press
// sequences, the zero poll interval, counter saturation, output
// backpressure, and random press sequences under a range of register
// settings.
// ----------------------------------------------------------------------------
module tb_two_key_click_hold_detector_top;

    import tkchd_pkg::*;

    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_LO = CFG_RELEASE_THR + 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_HI = '1;
    localparam int                   CNT_W         = COUNT_WIDTH_DEF;
    localparam int                   RES_W         = $bits(result_t);

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [S_DATA_W-1:0]   s_tdata   = '0;   // up, down, read_ok, zero fill
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [M_DATA_W-1:0]   m_tdata;          // status[3:0], ev_valid, key[1:0], kind[1:0]
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    // shadow of the block's registers and scan machine
    cfg_t             reg_shadow;
    scan_step_t       scan;
    level_t           held_level;
    logic [CNT_W-1:0] settle_ms;
    logic [CNT_W-1:0] repeat_ms;

    result_t pending_results [$];

    bit jitter_on     = 1'b1;
    int hold_off_left = 0;
    int failures      = 0;
    int checked       = 0;
    int ok_ticks      = 0;
    int failed_reads  = 0;
    int input_stalls  = 0;
    int settings_used = 0;
    int status_seen [16];

    two_key_click_hold_detector_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // prediction
    // ------------------------------------------------------------------
    function automatic logic [CNT_W-1:0] bump(logic [CNT_W-1:0] acc, logic [POLL_W-1:0] ms);
        logic [CNT_W:0] sum;
        sum = {1'b0, acc} + (CNT_W+1)'(ms);
        return sum[CNT_W] ? '1 : sum[CNT_W-1:0];
    endfunction

    // status codes come in blocks of three per level
    function automatic logic [3:0] status_code(level_t lev, press_kind_t kind);
        case (lev)
            LEV_UP:   return ST_IDLE + 4'(kind);
            LEV_DOWN: return ST_UP_CONT + 4'(kind);
            LEV_BOTH: return ST_DN_CONT + 4'(kind);
            default:  return ST_IDLE;
        endcase
    endfunction

    function automatic result_t next_key_result(pin_item_t p);
        result_t           r;
        logic [3:0]        st;
        logic [POLL_W-1:0] ms;
        level_t            lev;
        st = ST_IDLE;
        if (p.read_ok)
        begin
            ms  = (reg_shadow.poll_ms == '0) ? DEFAULT_POLL_MS : reg_shadow.poll_ms;
            lev = level_t'({p.down_pin_level ^ reg_shadow.press_low,
                            p.up_pin_level ^ reg_shadow.press_low});
            case (scan)
                STEP_WAIT:
                begin
                    if (lev != LEV_NONE)
                    begin
                        settle_ms  = '0;
                        repeat_ms  = '0;
                        scan       = STEP_DEBOUNCE;
                        held_level = lev;
                    end
                end
                STEP_DEBOUNCE:
                begin
                    if (lev == held_level)
                    begin
                        settle_ms = bump(settle_ms, ms);
                        if (settle_ms >= reg_shadow.hold_thr)
                        begin
                            scan      = STEP_HOLD;
                            settle_ms = '0;
                            st        = status_code(held_level, KIND_ENTER);
                        end
                    end
                    else if (lev == LEV_NONE)
                    begin
                        if (settle_ms >= reg_shadow.click_thr)
                            st = status_code(held_level, KIND_CLICK);
                        scan      = STEP_WAIT;
                        settle_ms = '0;
                        repeat_ms = '0;
                    end
                    else if (lev == LEV_BOTH)
                    begin
                        held_level = LEV_BOTH;
                        settle_ms  = '0;
                    end
                    else if (held_level == LEV_BOTH && settle_ms >= reg_shadow.click_thr)
                    begin
                        // leaving both keys after the threshold: dual click
                        st        = status_code(LEV_BOTH, KIND_CLICK);
                        scan      = STEP_HOLD;
                        settle_ms = '0;
                        repeat_ms = '0;
                    end
                    else
                    begin
                        held_level = lev;
                        settle_ms  = '0;
                    end
                end
                STEP_HOLD:
                begin
                    if (lev == LEV_NONE)
                    begin
                        settle_ms = bump(settle_ms, ms);
                        if (settle_ms >= reg_shadow.release_thr)
                        begin
                            scan      = STEP_WAIT;
                            settle_ms = '0;
                            repeat_ms = '0;
                        end
                    end
                    else
                    begin
                        settle_ms = '0;
                        repeat_ms = bump(repeat_ms, ms);
                        if (repeat_ms >= reg_shadow.hold_thr)
                        begin
                            st        = status_code(held_level, KIND_CONT);
                            repeat_ms = '0;
                        end
                    end
                end
                default:
                begin
                    scan      = STEP_WAIT;
                    settle_ms = '0;
                    repeat_ms = '0;
                end
            endcase
        end

        r            = '0;
        r.key_status = st;
        case (st)
            ST_UP_CLICK, ST_DN_CLICK:
            begin
                r.app_event_valid = 1'b1;
                r.app_key_index   = (st == ST_UP_CLICK) ? APP_KEY_UP : APP_KEY_DOWN;
                r.app_event_kind  = APP_EV_CLICK;
            end
            // both-keys hold-enter goes out on the up key
            ST_UP_ENTER, ST_DN_ENTER, ST_BOTH_ENTER:
            begin
                r.app_event_valid = 1'b1;
                r.app_key_index   = (st == ST_DN_ENTER) ? APP_KEY_DOWN : APP_KEY_UP;
                r.app_event_kind  = APP_EV_LONG;
            end
            ST_BOTH_CLICK:
            begin
                r.app_event_valid = 1'b1;
                r.app_key_index   = APP_KEY_BOTH;
                r.app_event_kind  = APP_EV_DUAL;
            end
            default:
            begin
                r.app_event_valid = 1'b0;
            end
        endcase
        return r;
    endfunction

    task automatic reset_shadow();
        reg_shadow.press_low   = 1'b1;
        reg_shadow.poll_ms     = 8'd10;
        reg_shadow.hold_thr    = 16'd1000;
        reg_shadow.click_thr   = 16'd30;
        reg_shadow.release_thr = 16'd50;
        scan                   = STEP_WAIT;
        held_level             = LEV_NONE;
        settle_ms              = '0;
        repeat_ms              = '0;
    endtask

    // ------------------------------------------------------------------
    // drivers
    // ------------------------------------------------------------------
    task automatic push_poll_tick(input pin_item_t p);
        while (jitter_on && $urandom_range(0, 99) < 6)
        begin
            @(negedge clk);
            s_tvalid <= 1'b0;
        end
        @(negedge clk);
        s_tvalid <= 1'b1;
        s_tdata  <= S_DATA_W'(p);
        do
        begin
            @(posedge clk);
            if (!s_tready)
                input_stalls++;
        end
        while (!s_tready);
        pending_results.push_back(next_key_result(p));
        if (p.read_ok)
            ok_ticks++;
        else
            failed_reads++;
    endtask

    // one tick at a logical key level, optionally with failed reads and glitches mixed in
    task automatic press_tick(input level_t lev, input bit noisy);
        pin_item_t p;
        level_t    l;
        l = lev;
        if (noisy && $urandom_range(0, 99) < 5)
        begin
            p = pin_item_t'({1'b0, 2'($urandom)});
            push_poll_tick(p);
        end
        if (noisy && $urandom_range(0, 99) < 3)
            l = level_t'($urandom_range(0, 3));
        p.read_ok        = 1'b1;
        p.up_pin_level   = l[0] ^ reg_shadow.press_low;
        p.down_pin_level = l[1] ^ reg_shadow.press_low;
        push_poll_tick(p);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        case (idx)
            CFG_PRESS_LOW:   reg_shadow.press_low   = value[0];
            CFG_POLL_MS:     reg_shadow.poll_ms     = value[POLL_W-1:0];
            CFG_HOLD_THR:    reg_shadow.hold_thr    = value;
            CFG_CLICK_THR:   reg_shadow.click_thr   = value;
            CFG_RELEASE_THR: reg_shadow.release_thr = value;
            default:         ;
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic apply_settings(input logic [15:0] al, input logic [15:0] poll,
                                  input logic [15:0] hold, input logic [15:0] click,
                                  input logic [15:0] rel);
        write_reg(CFG_PRESS_LOW, al);
        write_reg(CFG_POLL_MS, poll);
        write_reg(CFG_HOLD_THR, hold);
        write_reg(CFG_CLICK_THR, click);
        write_reg(CFG_RELEASE_THR, rel);
        settings_used++;
    endtask

    task automatic settle_idle();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    function automatic logic [15:0] clip16(int v);
        return (v > 65535) ? 16'hFFFF : 16'(v);
    endfunction

    task automatic shuffle_settings();
        int         pick;
        int         eff;
        logic [7:0] poll;
        pick = $urandom_range(0, 9);
        poll = (pick == 0) ? 8'd0 : (pick == 1) ? 8'd1 : (pick == 2) ? 8'd255
             : 8'($urandom_range(1, 255));
        eff  = (poll == 0) ? int'(DEFAULT_POLL_MS) : int'(poll);
        apply_settings({15'($urandom), 1'($urandom)},
                       {8'($urandom), poll},
                       ($urandom_range(0, 99) < 5) ? 16'd0
                       : clip16(eff * $urandom_range(1, 10) + $urandom_range(0, eff - 1)),
                       ($urandom_range(0, 99) < 5) ? 16'hFFFF
                       : clip16(eff * $urandom_range(0, 3) + $urandom_range(0, eff - 1)),
                       ($urandom_range(0, 99) < 5) ? 16'd0
                       : clip16(eff * $urandom_range(0, 5) + $urandom_range(0, eff - 1)));
        write_reg(3'($urandom_range(CFG_UNUSED_LO, CFG_UNUSED_HI)), 16'($urandom));
    endtask

    // press/release runs with random length and content
    task automatic random_phase(input int ticks_wanted);
        int     made;
        int     eff;
        int     press_lim;
        int     rel_lim;
        int     nseg;
        level_t lev;
        eff       = (reg_shadow.poll_ms == '0) ? int'(DEFAULT_POLL_MS) : int'(reg_shadow.poll_ms);
        press_lim = int'(reg_shadow.hold_thr) / eff * 2 + 4;
        press_lim = (press_lim > 40) ? 40 : press_lim;
        rel_lim   = int'(reg_shadow.release_thr) / eff * 2 + 3;
        rel_lim   = (rel_lim > 30) ? 30 : rel_lim;
        made      = 0;
        while (made < ticks_wanted)
        begin
            nseg = ($urandom_range(0, 9) < 7) ? 1 : $urandom_range(2, 3);
            repeat (nseg)
            begin
                lev = level_t'($urandom_range(LEV_UP, LEV_BOTH));
                repeat ($urandom_range(1, press_lim))
                begin
                    press_tick(lev, 1'b1);
                    made++;
                end
            end
            repeat ($urandom_range(1, rel_lim))
            begin
                press_tick(LEV_NONE, 1'b1);
                made++;
            end
        end
    endtask

    // ------------------------------------------------------------------
    // receiver and checker
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (hold_off_left > 0)
        begin
            m_tready <= 1'b0;
            hold_off_left = hold_off_left - 1;
        end
        else
            m_tready <= !(jitter_on && $urandom_range(0, 99) < 6);
    end

    always @(posedge clk)
    begin : check_results
        result_t got;
        result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = result_t'(m_tdata[RES_W-1:0]);
            if (pending_results.size() == 0)
            begin
                failures++;
                if (failures <= 10)
                    $display("unexpected result at %0t: status %0d", $time, got.key_status);
            end
            else
            begin
                want = pending_results.pop_front();
                checked++;
                status_seen[want.key_status]++;
                if (got.key_status !== want.key_status
                    || got.app_event_valid !== want.app_event_valid
                    || got.app_key_index !== want.app_key_index
                    || got.app_event_kind !== want.app_event_kind)
                begin
                    failures++;
                    if (failures <= 10)
                        $display("mismatch at %0t: exp st=%0d ev=%0b key=%0d kind=%0d,",
                                 $time, want.key_status, want.app_event_valid,
                                 want.app_key_index, want.app_event_kind,
                                 " got st=%0d ev=%0b key=%0d kind=%0d",
                                 got.key_status, got.app_event_valid,
                                 got.app_key_index, got.app_event_kind);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------
    task automatic test_reset_defaults();
        // register defaults: low level pressed, 10 ms poll, 30 ms click
        repeat (4) press_tick(LEV_UP, 1'b0);
        press_tick(LEV_NONE, 1'b0);
    endtask

    task automatic test_directed_sequences();
        pin_item_t script [22];
        settle_idle();
        apply_settings(16'hFFFE, 16'd100, 16'd300, 16'd100, 16'd200);
        // {read_ok, down, up}, keys active high here
        script = '{3'b101, 3'b100,                              // short press, no click
                   3'b110, 3'b110, 3'b100,                      // down click
                   3'b111, 3'b011, 3'b111, 3'b110,              // dual click, failed read inside
                   3'b000, 3'b100, 3'b100,                      // release from hold
                   3'b101, 3'b110, 3'b110, 3'b110, 3'b110,      // up to down, down hold-enter
                   3'b110, 3'b110, 3'b110,                      // down hold-continue
                   3'b100, 3'b100};
        foreach (script[i])
            push_poll_tick(script[i]);
    endtask

    task automatic test_zero_poll();
        pin_item_t script [14];
        settle_idle();
        // poll of zero falls back to the default interval; junk above the field
        apply_settings(16'h0001, 16'hFF00, 16'd20, 16'd0, 16'd1);
        script = '{3'b110, 3'b110, 3'b110, 3'b110, 3'b110, 3'b111,   // up enter, continue
                   3'b100, 3'b100, 3'b100, 3'b100, 3'b100, 3'b111,   // both enter, continue
                   3'b110, 3'b111};                                  // click at zero threshold
        foreach (script[i])
            push_poll_tick(script[i]);
    endtask

    task automatic test_output_backpressure();
        settle_idle();
        jitter_on     = 1'b0;
        hold_off_left = 64;
        repeat (40) press_tick(level_t'($urandom_range(0, 3)), 1'b0);
        jitter_on     = 1'b1;
    endtask

    task automatic test_counter_saturation();
        settle_idle();
        // 254 ms steps step over the 16-bit ceiling instead of landing on it
        apply_settings(16'h0001, 16'd254, 16'hFFFF, 16'd0, 16'hFFFF);
        repeat (260) press_tick(LEV_UP, 1'b0);
        repeat (259) press_tick(LEV_UP, 1'b0);
        repeat (2) press_tick(LEV_NONE, 1'b0);
    endtask

    task automatic test_random_settings();
        for (int ph = 0; ph < 6; ph++)
        begin
            settle_idle();
            case (ph)
                0:       apply_settings(16'd1, 16'd1, 16'd1, 16'd0, 16'd1);
                1:       apply_settings(16'd0, 16'd255, 16'hFFFF, 16'hFFFF, 16'hFFFF);
                default: shuffle_settings();
            endcase
            jitter_on = (ph != 3);
            random_phase((ph == 1) ? 30 : 40);
        end
        jitter_on = 1'b1;
    endtask

    initial
    begin
        reset_shadow();
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_reset_defaults();
        test_directed_sequences();
        test_zero_poll();
        test_output_backpressure();
        test_counter_saturation();
        test_random_settings();
        settle_idle();

        $display("covered %0d poll ticks and %0d failed reads over %0d register settings,",
                 ok_ticks, failed_reads, settings_used,
                 " %0d input stall cycles", input_stalls);
        $display("checked %0d results: %0d clicks, %0d dual clicks,",
                 checked, status_seen[ST_UP_CLICK] + status_seen[ST_DN_CLICK],
                 status_seen[ST_BOTH_CLICK],
                 " %0d hold-enters, %0d hold-continues",
                 status_seen[ST_UP_ENTER] + status_seen[ST_DN_ENTER] + status_seen[ST_BOTH_ENTER],
                 status_seen[ST_UP_CONT] + status_seen[ST_DN_CONT] + status_seen[ST_BOTH_CONT]);
        if (failures == 0 && pending_results.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    initial
    begin
        #3000000;
        $display("FAILURE");
        $finish;
    end

endmodule
